[hw/rtl/bia_pkg.sv]
// shared constants, codes and types for the bitmap id allocator
package bia_pkg;

  localparam int ID_SPACE  = 8192;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = (ID_SPACE + WORD_BITS - 1) / WORD_BITS;
  localparam int ID_W      = $clog2(ID_SPACE);
  localparam int LIM_W     = ID_W + 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(MAP_WORDS);
  localparam int ST_W      = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [ID_W-1:0]  MIN_ID_RST   = ID_W'(300);
  localparam logic [LIM_W-1:0] ID_LIMIT_RST = LIM_W'(5000);

  typedef enum logic [0:0] {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_t;

  typedef enum logic [ST_W-1:0] {
    ST_ALLOCATED    = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_RELEASED     = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_MIN_ID   = 1'b0,
    REG_ID_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic                 re;
    logic [WADDR_W-1:0]   raddr;
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] new_word;
  } scan_res_t;

endpackage

[hw/rtl/bia_req_if.sv]
// request channel: valid/ready with the request word
interface bia_req_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [bia_pkg::ID_W-1:0] release_id;

  modport source (output valid, req_type, release_id, input ready);
  modport sink   (input valid, req_type, release_id, output ready);
endinterface

[hw/rtl/bia_rsp_if.sv]
// response channel: valid/ready with the result word
interface bia_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [bia_pkg::ID_W-1:0] granted_id;
  logic [bia_pkg::ST_W-1:0] status;

  modport source (output valid, granted_id, status, input ready);
  modport sink   (input valid, granted_id, status, output ready);
endinterface

[hw/rtl/bia_cfg.sv]
// apb configuration registers: min_id and id_limit
module bia_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bia_pkg::APB_AW-1:0]    paddr,
  input  logic [bia_pkg::APB_DW-1:0]    pwdata,
  output logic [bia_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [bia_pkg::ID_W-1:0]      min_id,
  output logic [bia_pkg::LIM_W-1:0]     id_limit
);

  logic            wr_en;
  bia_pkg::reg_idx_t sel;

  assign pready = 1'b1;
  assign sel    = bia_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_id   <= bia_pkg::MIN_ID_RST;
      id_limit <= bia_pkg::ID_LIMIT_RST;
    end else if (wr_en) begin
      unique case (sel)
        bia_pkg::REG_MIN_ID:   min_id   <= pwdata[bia_pkg::ID_W-1:0];
        bia_pkg::REG_ID_LIMIT: id_limit <= pwdata[bia_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      bia_pkg::REG_MIN_ID:   prdata = bia_pkg::APB_DW'(min_id);
      bia_pkg::REG_ID_LIMIT: prdata = bia_pkg::APB_DW'(id_limit);
      default:               prdata = '0;
    endcase
  end

endmodule

[hw/rtl/bia_map_ram.sv]
// bitmap word memory with per-word valid bits; an unwritten word reads as all free
module bia_map_ram (
  input  logic                             clk,
  input  logic                             rst,
  input  bia_pkg::ram_cmd_t                cmd,
  output logic [bia_pkg::WORD_BITS-1:0]    rword
);

  logic [bia_pkg::WORD_BITS-1:0] mem [bia_pkg::MAP_WORDS];
  logic [bia_pkg::MAP_WORDS-1:0] valid;
  logic [bia_pkg::WORD_BITS-1:0] rdata;
  logic                          rvalid;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata  <= mem[cmd.raddr];
      rvalid <= valid[cmd.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.we) begin
      valid[cmd.waddr] <= 1'b1;
    end
  end

  assign rword = rvalid ? rdata : '0;

endmodule

[hw/rtl/bia_scan.sv]
// word unit: masks one bitmap word to the id range, finds the lowest free bit, builds the update
module bia_scan (
  input  logic [bia_pkg::WORD_BITS-1:0] word,
  input  logic                          is_release,
  input  logic [bia_pkg::BIT_W-1:0]     rel_bit,
  input  logic [bia_pkg::BIT_W-1:0]     lo_bit,
  input  logic [bia_pkg::BIT_W-1:0]     hi_bit,
  output bia_pkg::scan_res_t            res
);

  logic [bia_pkg::WORD_BITS-1:0] mask;
  logic [bia_pkg::WORD_BITS-1:0] free_bits;
  logic [bia_pkg::WORD_BITS-1:0] onehot;
  logic [bia_pkg::BIT_W-1:0]     low_free;
  logic [bia_pkg::BIT_W-1:0]     sel_bit;

  assign mask = ({bia_pkg::WORD_BITS{1'b1}} << lo_bit)
              & ({bia_pkg::WORD_BITS{1'b1}} >> (bia_pkg::BIT_W'(bia_pkg::WORD_BITS - 1) - hi_bit));
  assign free_bits = ~word & mask;

  // lowest set bit wins
  always_comb begin
    low_free = '0;
    for (int i = bia_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        low_free = bia_pkg::BIT_W'(i);
      end
    end
  end

  assign sel_bit = is_release ? rel_bit : low_free;
  assign onehot  = bia_pkg::WORD_BITS'(1) << sel_bit;

  assign res.found    = |free_bits;
  assign res.bit_idx  = sel_bit;
  assign res.new_word = is_release ? (word & ~onehot) : (word | onehot);

endmodule

[hw/rtl/bia_seq.sv]
// request sequencer: range checks, word-by-word scan, bitmap update and result register
module bia_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bia_pkg::ID_W-1:0]      min_id,
  input  logic [bia_pkg::LIM_W-1:0]     id_limit,
  bia_req_if.sink                       req,
  bia_rsp_if.source                     rsp,
  output bia_pkg::ram_cmd_t             cmd,
  input  logic [bia_pkg::WORD_BITS-1:0] rword
);

  bia_pkg::seq_state_t state, state_next;

  logic                            is_rel, is_rel_next;
  logic [bia_pkg::ID_W-1:0]        rid, rid_next;
  logic [bia_pkg::WADDR_W-1:0]     ridx, ridx_next;
  logic [bia_pkg::WADDR_W-1:0]     eidx, eidx_next;
  logic [bia_pkg::ID_W-1:0]        res_id, res_id_next;
  bia_pkg::status_t                res_st, res_st_next;
  logic                            out_valid, out_valid_next;
  logic [bia_pkg::ID_W-1:0]        out_id, out_id_next;
  bia_pkg::status_t                out_st, out_st_next;

  logic [bia_pkg::LIM_W-1:0]       eff;
  logic [bia_pkg::LIM_W-1:0]       eff_m1;
  logic [bia_pkg::WADDR_W-1:0]     last_w;
  logic                            range_empty;
  logic                            rid_bad;
  logic                            accept;
  logic                            out_free;
  logic [bia_pkg::BIT_W-1:0]       lo_bit;
  logic [bia_pkg::BIT_W-1:0]       hi_bit;
  bia_pkg::scan_res_t              sres;

  assign eff = (id_limit > bia_pkg::LIM_W'(bia_pkg::ID_SPACE))
             ? bia_pkg::LIM_W'(bia_pkg::ID_SPACE) : id_limit;
  assign eff_m1      = eff - bia_pkg::LIM_W'(1);
  assign last_w      = eff_m1[bia_pkg::ID_W-1:bia_pkg::BIT_W];
  assign range_empty = bia_pkg::LIM_W'(min_id) >= eff;
  assign rid_bad     = (req.release_id < min_id) || (bia_pkg::LIM_W'(req.release_id) >= eff);

  assign req.ready = (state == bia_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // range edges only clip the first and last words of the scan
  assign lo_bit = (eidx == min_id[bia_pkg::ID_W-1:bia_pkg::BIT_W])
                ? min_id[bia_pkg::BIT_W-1:0] : '0;
  assign hi_bit = (eidx == last_w) ? eff_m1[bia_pkg::BIT_W-1:0]
                : bia_pkg::BIT_W'(bia_pkg::WORD_BITS - 1);

  bia_scan u_scan (
    .word       (rword),
    .is_release (is_rel),
    .rel_bit    (rid[bia_pkg::BIT_W-1:0]),
    .lo_bit     (lo_bit),
    .hi_bit     (hi_bit),
    .res        (sres)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bia_pkg::S_IDLE: begin
        if (accept) begin
          if (req.req_type == bia_pkg::REQ_RELEASE) begin
            state_next = rid_bad ? bia_pkg::S_OUT : bia_pkg::S_FETCH;
          end else begin
            state_next = range_empty ? bia_pkg::S_OUT : bia_pkg::S_FETCH;
          end
        end
      end
      bia_pkg::S_FETCH: state_next = bia_pkg::S_SCAN;
      bia_pkg::S_SCAN: begin
        if (is_rel || sres.found || eidx == last_w) begin
          state_next = bia_pkg::S_OUT;
        end
      end
      bia_pkg::S_OUT: begin
        if (out_free) begin
          state_next = bia_pkg::S_IDLE;
        end
      end
      default: state_next = bia_pkg::S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    is_rel_next    = is_rel;
    rid_next       = rid;
    ridx_next      = ridx;
    eidx_next      = eidx;
    res_id_next    = res_id;
    res_st_next    = res_st;
    out_valid_next = out_valid && !rsp.ready;
    out_id_next    = out_id;
    out_st_next    = out_st;
    cmd.re         = 1'b0;
    cmd.raddr      = ridx;
    cmd.we         = 1'b0;
    cmd.waddr      = eidx;
    cmd.wdata      = sres.new_word;
    unique case (state)
      bia_pkg::S_IDLE: begin
        if (accept) begin
          is_rel_next = (req.req_type == bia_pkg::REQ_RELEASE);
          rid_next    = req.release_id;
          res_id_next = '0;
          if (req.req_type == bia_pkg::REQ_RELEASE) begin
            ridx_next   = req.release_id[bia_pkg::ID_W-1:bia_pkg::BIT_W];
            res_st_next = bia_pkg::ST_OUT_OF_RANGE;
          end else begin
            ridx_next   = min_id[bia_pkg::ID_W-1:bia_pkg::BIT_W];
            res_st_next = bia_pkg::ST_NONE_FREE;
          end
        end
      end
      bia_pkg::S_FETCH: begin
        cmd.re    = 1'b1;
        eidx_next = ridx;
        ridx_next = ridx + bia_pkg::WADDR_W'(1);
      end
      bia_pkg::S_SCAN: begin
        if (is_rel) begin
          cmd.we      = 1'b1;
          res_st_next = bia_pkg::ST_RELEASED;
        end else if (sres.found) begin
          cmd.we      = 1'b1;
          res_st_next = bia_pkg::ST_ALLOCATED;
          res_id_next = {eidx, sres.bit_idx};
        end else if (eidx != last_w) begin
          // read of the next word overlaps the check of this one
          cmd.re    = 1'b1;
          eidx_next = ridx;
          ridx_next = ridx + bia_pkg::WADDR_W'(1);
        end
      end
      bia_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_id_next    = res_id;
          out_st_next    = res_st;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bia_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    is_rel <= is_rel_next;
    rid    <= rid_next;
    ridx   <= ridx_next;
    eidx   <= eidx_next;
    res_id <= res_id_next;
    res_st <= res_st_next;
    out_id <= out_id_next;
    out_st <= out_st_next;
  end

  assign rsp.valid      = out_valid;
  assign rsp.granted_id = out_id;
  assign rsp.status     = out_st;

endmodule

[hw/rtl/bitmap_id_allocator.sv]
// lowest-free bitmap id allocator, top level
// allocate: words scanned in order from min_id's word until a bit is free, up to 256 words
// next request taken once the result is loaded into the result register
// in-range release: S_FETCH, S_SCAN, S_OUT; out-of-range release or empty allocate: S_OUT only
// reset: synchronous, clears per-word valid bits so the whole map reads free at once
// reset also loads min_id 300 and id_limit 5000 and empties the result register
module bitmap_id_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bia_pkg::APB_AW-1:0]    paddr,
  input  logic [bia_pkg::APB_DW-1:0]    pwdata,
  output logic [bia_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  bia_req_if.sink                       req,
  bia_rsp_if.source                     rsp
);

  logic [bia_pkg::ID_W-1:0]      min_id;
  logic [bia_pkg::LIM_W-1:0]     id_limit;
  bia_pkg::ram_cmd_t             cmd;
  logic [bia_pkg::WORD_BITS-1:0] rword;

  bia_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .min_id   (min_id),
    .id_limit (id_limit)
  );

  bia_map_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rword (rword)
  );

  bia_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .min_id   (min_id),
    .id_limit (id_limit),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .rword    (rword)
  );

  // a granted id lies inside the configured range
  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == bia_pkg::ST_ALLOCATED |->
      rsp.granted_id >= min_id && bia_pkg::LIM_W'(rsp.granted_id) < id_limit)
    else $error("granted id outside range");

  // granted_id is zero on every non-allocate result
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != bia_pkg::ST_ALLOCATED |-> rsp.granted_id == '0)
    else $error("nonzero id on non-allocate result");

  // one request at a time: ready drops after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second request taken while busy");

  // the bitmap is only written while no request can be taken
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> !req.ready)
    else $error("bitmap write while idle");

endmodule
